FILE: rtl/core/tile_print_job_sequencer_macros.svh
// Assertion macros for the tile print job sequencer checker
`ifndef TILE_PRINT_JOB_SEQUENCER_MACROS_SVH
`define TILE_PRINT_JOB_SEQUENCER_MACROS_SVH

// check on every clock edge outside reset
`define TPJS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define TPJS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/tpjs_pkg.sv
// Shared constants, types and functions of the tile print job sequencer
`timescale 1ns / 1ps
`default_nettype none
package tpjs_pkg;

    localparam int CHAR_COUNT  = 40;
    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_COUNT = 10;

    localparam int ROW_COUNT = CHAR_COUNT * 8;
    localparam int ROW_AW    = $clog2(ROW_COUNT);
    localparam int LOAD_W    = $clog2(ROW_COUNT + 1);
    localparam int BC_W      = 4;
    localparam int TILE_W    = $clog2((2 ** BC_W) * BLOCK_BYTES);
    localparam int BYTE_CW   = $clog2(BLOCK_BYTES);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int PADDR_W = 3;
    localparam logic REG_INVERT = 1'b0;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_ACK  = 8'h61;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_O    = 8'h4F;

    localparam logic [1:0] EXPO_LAST = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       job_done;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_BANG  = 3'd1,
        CMD_BURST = 3'd2,
        CMD_EXPO  = 3'd3,
        CMD_DONE  = 3'd4
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [ROW_AW-1:0] row;
        logic [TILE_W-1:0] base;
        logic [7:0]        data;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_qin;

    typedef struct packed {
        logic empty;
        t_cmd head;
    } t_qout;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    function automatic logic [7:0] expo_byte(input logic [1:0] i);
        logic [7:0] b;
        unique case (i)
            2'd0: b = 8'h01;
            2'd1: b = 8'h00;
            2'd2: b = 8'hE4;
            2'd3: b = 8'h40;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tpjs_fifo.sv
// Command queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none
module tpjs_fifo
    import tpjs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_qin  i_push,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_qout      o_q
);

    t_cmd           r_q [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == (QAW + 1)'(QDEPTH));
    assign o_q.empty = (r_cnt == '0);
    assign o_q.head  = r_q[r_rp];

    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && !o_q.empty;

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tpjs_front.sv
// Front end: accept input beats, track the job phase, queue commands
`timescale 1ns / 1ps
`default_nettype none
module tpjs_front
    import tpjs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in,
    output logic          o_in_ready,
    input  wire logic     i_q_full,
    output t_qin          o_q
);

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_WAIT_ACK = 5'b00010,
        PH_WAIT_ONE = 5'b00100,
        PH_WAIT_P   = 5'b01000,
        PH_WAIT_O   = 5'b10000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BC_W-1:0]   r_block_count, n_block_count;
    logic [LOAD_W-1:0] r_load_index, n_load_index;
    logic [BC_W-1:0]   bc_inc;
    logic              accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign bc_inc     = r_block_count + 1'b1;

    always_comb begin
        n_phase       = r_phase;
        n_block_count = r_block_count;
        n_load_index  = r_load_index;
        o_q.push      = 1'b0;
        o_q.cmd.kind  = CMD_LOAD;
        o_q.cmd.row   = r_load_index[ROW_AW-1:0];
        o_q.cmd.base  = TILE_W'(int'(r_block_count) * BLOCK_BYTES);
        o_q.cmd.data  = i_in.value;
        if (accept) begin
            unique case (i_in.op)
                OP_LOAD: begin
                    if (int'(r_load_index) < ROW_COUNT) begin
                        o_q.push     = 1'b1;
                        n_load_index = r_load_index + 1'b1;
                    end
                end
                OP_START: begin
                    o_q.push      = 1'b1;
                    o_q.cmd.kind  = CMD_BANG;
                    n_block_count = '0;
                    n_phase       = PH_WAIT_ACK;
                end
                OP_RX: begin
                    unique case (r_phase)
                        PH_WAIT_ACK: begin
                            if (i_in.value == CH_ACK) begin
                                o_q.push      = 1'b1;
                                o_q.cmd.kind  = CMD_BURST;
                                n_block_count = bc_inc;
                                if (int'(bc_inc) >= BLOCK_COUNT) begin
                                    n_phase = PH_WAIT_ONE;
                                end
                            end
                        end
                        PH_WAIT_ONE: begin
                            if (i_in.value == CH_ONE) begin
                                o_q.push     = 1'b1;
                                o_q.cmd.kind = CMD_EXPO;
                                n_phase      = PH_WAIT_P;
                            end
                        end
                        PH_WAIT_P: begin
                            if (i_in.value == CH_P) begin
                                n_phase = PH_WAIT_O;
                            end
                        end
                        PH_WAIT_O: begin
                            if (i_in.value == CH_O) begin
                                o_q.push      = 1'b1;
                                o_q.cmd.kind  = CMD_DONE;
                                n_phase       = PH_IDLE;
                                n_block_count = '0;
                                n_load_index  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_block_count <= '0;
            r_load_index  <= '0;
        end else begin
            r_phase       <= n_phase;
            r_block_count <= n_block_count;
            r_load_index  <= n_load_index;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tpjs_back.sv
// Back end: row store, burst and byte sequencing, output register
`timescale 1ns / 1ps
`default_nettype none
module tpjs_back
    import tpjs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_qout i_q,
    output logic       o_pop,
    input  wire logic  i_invert,
    output logic       o_out_valid,
    output t_out_item  o_out,
    input  wire logic  i_out_ready
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_BURST = 3'b010,
        B_EXPO  = 3'b100
    } t_bstate;

    t_bstate            r_state, n_state;
    logic [BYTE_CW-1:0] r_idx, n_idx;
    logic [TILE_W-1:0]  r_base, n_base;

    logic [7:0]         r_mem [0:ROW_COUNT-1];
    logic [7:0]         r_rd_data;

    logic               r_p_valid;
    logic               r_p_tile, r_p_zero, r_p_done, r_p_last;
    logic [7:0]         r_p_byte;

    logic               r_o_valid;
    t_out_item          r_o, n_o;

    logic               o_free, p_free;
    logic               issue, wr_en, rd_en;
    logic               p_tile, p_zero, p_done, p_last;
    logic [7:0]         p_byte;
    logic [TILE_W-1:0]  tile;
    logic [TILE_W-2:0]  row;
    logic               in_range;
    logic [ROW_AW-1:0]  rd_addr;
    logic [7:0]         tile_b;

    assign o_free   = !r_o_valid || i_out_ready;
    assign p_free   = !r_p_valid || o_free;
    assign tile     = r_base + TILE_W'(r_idx);
    assign row      = tile[TILE_W-1:1];
    assign in_range = int'(row) < ROW_COUNT;
    assign rd_addr  = ROW_AW'(row);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_base  = r_base;
        o_pop   = 1'b0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        issue   = 1'b0;
        p_tile  = 1'b0;
        p_zero  = 1'b0;
        p_done  = 1'b0;
        p_last  = 1'b0;
        p_byte  = '0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q.empty) begin
                    unique case (i_q.head.kind)
                        CMD_LOAD: begin
                            o_pop = 1'b1;
                            wr_en = 1'b1;
                        end
                        CMD_BANG: begin
                            if (p_free) begin
                                o_pop  = 1'b1;
                                issue  = 1'b1;
                                p_byte = CH_BANG;
                                p_last = 1'b1;
                            end
                        end
                        CMD_BURST: begin
                            o_pop   = 1'b1;
                            n_state = B_BURST;
                            n_idx   = '0;
                            n_base  = i_q.head.base;
                        end
                        CMD_EXPO: begin
                            o_pop   = 1'b1;
                            n_state = B_EXPO;
                            n_idx   = '0;
                        end
                        CMD_DONE: begin
                            if (p_free) begin
                                o_pop  = 1'b1;
                                issue  = 1'b1;
                                p_done = 1'b1;
                                p_last = 1'b1;
                            end
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            B_BURST: begin
                if (p_free) begin
                    issue  = 1'b1;
                    p_tile = 1'b1;
                    p_zero = !in_range;
                    rd_en  = in_range;
                    p_last = (r_idx == BYTE_CW'(BLOCK_BYTES - 1));
                    n_idx  = r_idx + 1'b1;
                    if (p_last) begin
                        n_state = B_IDLE;
                    end
                end
            end
            B_EXPO: begin
                if (p_free) begin
                    issue  = 1'b1;
                    p_byte = expo_byte(r_idx[1:0]);
                    p_last = (r_idx[1:0] == EXPO_LAST);
                    n_idx  = r_idx + 1'b1;
                    if (p_last) begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_q.head.row] <= i_q.head.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        tile_b = r_p_zero ? 8'h00 : flip8(r_rd_data);
        if (i_invert) begin
            tile_b = ~tile_b;
        end
        n_o.tx_byte  = r_p_tile ? tile_b : r_p_byte;
        n_o.job_done = r_p_done;
        n_o.last     = r_p_last;
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_base <= n_base;
        if (issue) begin
            r_p_tile <= p_tile;
            r_p_zero <= p_zero;
            r_p_done <= p_done;
            r_p_last <= p_last;
            r_p_byte <= p_byte;
        end
        if (o_free) begin
            r_o <= n_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (issue) begin
                r_p_valid <= 1'b1;
            end else if (o_free) begin
                r_p_valid <= 1'b0;
            end
            if (o_free) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out       = r_o;

endmodule
`default_nettype wire

FILE: rtl/core/tile_print_job_sequencer.sv
// Top level of the tile print job sequencer: front end, queue, back end, registers
//
//   channel   direction  handshake                     payload
//   in        input      i_in_valid / o_in_ready       i_in  (op, value)
//   out       output     o_out_valid / i_out_ready     o_out (tx_byte, job_done, last)
//   cfg       input      psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One input beat per cycle while the four-entry command queue has room.
// A burst leaves at one byte per cycle while o_out is accepted: 64 beats through command
// decode, row read and output register; exposure bytes follow the same path, four beats.
// The '!' and done beats pass the queue, the pipeline register and the output register.
// Synchronous reset clears control state; the row store is not cleared.
// A stalled output holds the back end; the queue then fills and drops o_in_ready.
`timescale 1ns / 1ps
`default_nettype none
module tile_print_job_sequencer
    import tpjs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire t_in_item           i_in,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    output t_out_item               o_out,
    input  wire logic               i_out_ready,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic  r_invert;
    logic  q_full, q_pop;
    t_qin  q_in;
    t_qout q_out;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_INVERT);
    assign prdata = (paddr[2] == REG_INVERT) ? {31'b0, r_invert} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
        end else if (cfg_wr) begin
            r_invert <= pwdata[0];
        end
    end

    tpjs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .i_q_full   (q_full),
        .o_q        (q_in)
    );

    tpjs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_q     (q_out)
    );

    tpjs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q_out),
        .o_pop       (q_pop),
        .i_invert    (r_invert),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_ready (i_out_ready)
    );

endmodule
`default_nettype wire

FILE: rtl/core/tpjs_checker.sv
// Port-level checker for the tile print job sequencer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "tile_print_job_sequencer_macros.svh"
module tpjs_port_checker
    import tpjs_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire t_out_item          o_out,
    input wire logic               i_out_ready,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [PADDR_W-1:0] paddr,
    input wire logic [31:0]        pwdata,
    input wire logic [31:0]        prdata,
    input wire logic               pready
);

    logic        out_stall;
    logic        done_beat;
    logic        inv_sel;
    logic        inv_wr;
    logic [31:0] rd_want;

    assign out_stall = o_out_valid && !i_out_ready;
    assign done_beat = o_out_valid && o_out.job_done;
    assign inv_sel   = (paddr[2] == REG_INVERT);
    assign inv_wr    = psel && penable && pwrite && pready && inv_sel;
    assign rd_want   = {31'b0, pwdata[0]};

    `TPJS_ASSERT(a_out_hold, out_stall |=> o_out_valid && $stable(o_out), "stalled beat changed")
    `TPJS_ASSERT(a_done, done_beat |-> o_out.last && o_out.tx_byte == 8'h00, "bad done beat")
    `TPJS_ASSERT(a_cfg_rd, inv_wr |=> !inv_sel || prdata == $past(rd_want), "readback mismatch")
    `TPJS_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind tile_print_job_sequencer tpjs_port_checker u_tpjs_checker (.*);
`default_nettype wire

FILE: tb/tpjs_checker.sv
// Checker for the tile print job sequencer: predicts link bytes and compares every output beat
`timescale 1ns / 1ps
module tpjs_checker
    import tpjs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire t_in_item           i_in,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire t_out_item          i_out,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic               i_pready,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [31:0]        i_pwdata,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam logic [PADDR_W-1:0] INVERT_ADDR = PADDR_W'(4 * REG_INVERT);

    typedef enum logic [2:0] {
        JOB_IDLE,
        JOB_WAIT_ACK,
        JOB_WAIT_ONE,
        JOB_WAIT_P,
        JOB_WAIT_O
    } t_job_phase;

    t_job_phase        job_phase   = JOB_IDLE;
    logic [3:0]        blocks_sent = '0;
    logic [LOAD_W-1:0] rows_loaded = '0;
    logic [7:0]        band [ROW_COUNT];
    logic              negative    = 1'b0;
    t_out_item         link_q [$];
    int                fails       = 0;

    function automatic logic [7:0] print_byte(input int k);
        logic [7:0] row;
        logic [7:0] b;
        b = 8'h00;
        if ((k >> 1) < ROW_COUNT) begin
            row = band[k >> 1];
            b   = {<<{row}};
        end
        return negative ? ~b : b;
    endfunction

    function automatic void queue_beat(input logic [7:0] tx, input logic done, input logic fin);
        t_out_item e;
        e.tx_byte  = tx;
        e.job_done = done;
        e.last     = fin;
        link_q.push_back(e);
    endfunction

    function automatic void predict_item(input t_in_item it);
        case (it.op)
            OP_LOAD: begin
                if (rows_loaded < ROW_COUNT) begin
                    band[rows_loaded] = it.value;
                    rows_loaded++;
                end
            end
            OP_START: begin
                blocks_sent = '0;
                job_phase   = JOB_WAIT_ACK;
                queue_beat(CH_BANG, 1'b0, 1'b1);
            end
            OP_RX: begin
                case (job_phase)
                    JOB_WAIT_ACK: begin
                        if (it.value == CH_ACK) begin
                            for (int j = 0; j < BLOCK_BYTES; j++) begin
                                queue_beat(print_byte(int'(blocks_sent) * BLOCK_BYTES + j),
                                           1'b0, j == BLOCK_BYTES - 1);
                            end
                            blocks_sent++;
                            if (blocks_sent >= BLOCK_COUNT) job_phase = JOB_WAIT_ONE;
                        end
                    end
                    JOB_WAIT_ONE: begin
                        if (it.value == CH_ONE) begin
                            queue_beat(8'h01, 1'b0, 1'b0);
                            queue_beat(8'h00, 1'b0, 1'b0);
                            queue_beat(8'hE4, 1'b0, 1'b0);
                            queue_beat(8'h40, 1'b0, 1'b1);
                            job_phase = JOB_WAIT_P;
                        end
                    end
                    JOB_WAIT_P: begin
                        if (it.value == CH_P) job_phase = JOB_WAIT_O;
                    end
                    JOB_WAIT_O: begin
                        if (it.value == CH_O) begin
                            queue_beat(8'h00, 1'b1, 1'b1);
                            job_phase   = JOB_IDLE;
                            blocks_sent = '0;
                            rows_loaded = '0;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            job_phase   = JOB_IDLE;
            blocks_sent = '0;
            rows_loaded = '0;
            negative    = 1'b0;
            link_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (link_q.size() == 0) begin
                    $error("unexpected beat: tx_byte %02h job_done %0b last %0b",
                           i_out.tx_byte, i_out.job_done, i_out.last);
                    fails++;
                end else begin
                    want = link_q.pop_front();
                    if (i_out.tx_byte !== want.tx_byte) begin
                        $error("tx_byte: expected %02h, actual %02h",
                               want.tx_byte, i_out.tx_byte);
                        fails++;
                    end
                    if (i_out.job_done !== want.job_done) begin
                        $error("job_done: expected %0b, actual %0b",
                               want.job_done, i_out.job_done);
                        fails++;
                    end
                    if (i_out.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, i_out.last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_item(i_in);
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == INVERT_ADDR) begin
                negative = i_pwdata[0];
            end
        end
        o_pending    = link_q.size();
        o_fail_count = fails;
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the tile print job sequencer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb;
    import tpjs_pkg::*;

    localparam logic [1:0]         OP_SPARE     = 2'd3;
    localparam logic [PADDR_W-1:0] INVERT_ADDR  = PADDR_W'(4 * REG_INVERT);
    localparam int                 TOTAL_ITEMS  = 460;
    localparam int                 CFG_STRIDE   = 40;
    localparam int                 HOLD_CYCLES  = 400;
    localparam int                 DRAIN_CYCLES = 20;
    localparam int                 END_LIMIT    = 20000;
    localparam int                 TIMEOUT_NS   = 5_000_000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_item           in_beat   = '0;
    logic               in_ready;
    logic               out_valid;
    t_out_item          out_beat;
    logic               out_ready = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    int   fail_count;
    int   pending;
    int   burst_left = 0;
    int   items_sent = 0;
    logic hold_go    = 1'b0;

    always #5 clk = ~clk;

    tile_print_job_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_beat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out       (out_beat),
        .i_out_ready (out_ready),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    tpjs_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_beat),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_beat(input logic [1:0] op, input logic [7:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        in_valid      = 1'b1;
        in_beat.op    = op;
        in_beat.value = val;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1) == 0) send_beat(OP_RX, 8'($urandom));
        else send_beat(OP_SPARE, 8'($urandom));
    endtask

    task automatic send_loads(input int n);
        repeat (n) begin
            send_beat(OP_LOAD, 8'($urandom));
        end
    endtask

    task automatic write_invert(input logic v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = INVERT_ADDR;
        pwdata  = {31'b0, v};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic settle();
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_job();
        int stop_at;
        stop_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, BLOCK_COUNT + 2)
                                              : BLOCK_COUNT + 3;
        send_beat(OP_START, 8'($urandom));
        for (int b = 0; b < BLOCK_COUNT; b++) begin
            if (b == stop_at) return;
            if ($urandom_range(0, 4) == 0) send_noise();
            if ($urandom_range(0, 3) == 0) send_loads($urandom_range(1, 4));
            send_beat(OP_RX, CH_ACK);
        end
        if (stop_at == BLOCK_COUNT) return;
        if ($urandom_range(0, 4) == 0) send_noise();
        send_beat(OP_RX, CH_ONE);
        if (stop_at == BLOCK_COUNT + 1) return;
        if ($urandom_range(0, 4) == 0) send_noise();
        send_beat(OP_RX, CH_P);
        if (stop_at == BLOCK_COUNT + 2) return;
        if ($urandom_range(0, 4) == 0) send_noise();
        send_beat(OP_RX, CH_O);
    endtask

    initial begin : link_receiver
        int  mode;
        int  len;
        logic hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(20, 150);
            repeat (len) begin
                @(negedge clk);
                if (hold_go && !hold_done) begin
                    out_ready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = ($urandom_range(0, 3) != 0);
                    default: out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] v;
        logic       neg;
        int         next_cfg;
        int         waited;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        write_invert(1'b0);

        for (int r = 0; r < ROW_COUNT; r++) begin
            case (r)
                0: v = 8'h00;
                1: v = 8'hFF;
                2: v = 8'h01;
                3: v = 8'h80;
                default: v = 8'($urandom);
            endcase
            send_beat(OP_LOAD, v);
        end

        send_beat(OP_SPARE, 8'hFF);
        send_beat(OP_RX, CH_ACK);
        send_beat(OP_LOAD, 8'h55);
        send_beat(OP_START, 8'h00);
        send_beat(OP_RX, CH_ONE);
        send_beat(OP_START, 8'hFF);
        send_beat(OP_RX, CH_ACK);
        send_beat(OP_RX, CH_ACK);
        send_beat(OP_START, 8'h00);
        repeat (BLOCK_COUNT) send_beat(OP_RX, CH_ACK);
        send_beat(OP_RX, CH_ACK);
        send_beat(OP_RX, CH_ONE);
        send_beat(OP_RX, CH_O);
        send_beat(OP_RX, CH_P);
        send_beat(OP_RX, CH_P);
        send_beat(OP_RX, CH_O);

        neg = 1'b1;
        settle();
        write_invert(neg);
        hold_go  = 1'b1;
        next_cfg = items_sent + CFG_STRIDE;
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= next_cfg) begin
                settle();
                neg = ~neg;
                write_invert(neg);
                next_cfg += CFG_STRIDE;
            end
            if ($urandom_range(0, 9) < 8) run_job();
            else repeat ($urandom_range(1, 3)) send_noise();
            if ($urandom_range(0, 2) == 0) send_loads($urandom_range(1, 40));
        end

        waited = 0;
        while (pending != 0 && waited < END_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending != 0) $error("%0d expected beats never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
